// ===== rtl/cbdq_pkg.sv =====
// Shared types, constants and a bfloat16 conversion helper for the codebook dequantizer.
package cbdq_pkg;

	localparam int unsigned NumCodes  = 8;
	localparam int unsigned NumLanes  = 16;
	localparam int unsigned CodeW     = 3;
	localparam int unsigned BfW       = 16;
	localparam logic [15:0] BfQnan    = 16'h7FC0;

	typedef logic [BfW-1:0] bf16_t;
	typedef bf16_t [NumCodes-1:0] codebook_t;

	localparam codebook_t CodeReset = {
		16'h3E0A, 16'h3DAB, 16'h3D3E, 16'h3C79,
		16'hBC79, 16'hBD3E, 16'hBDAB, 16'hBE0A
	};

	// Classified operand after the multiplier stage
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        zero;
		logic [8:0]  esum;
		logic [15:0] prod;
	} lane_mid_t;

	function automatic bf16_t scale_to_bf16(input logic [31:0] f);
		logic [31:0] mag;
		bf16_t       r;
		mag = {1'b0, f[30:0]} + 32'h7FFF + {31'd0, f[16]};
		if (f[30:23] == 8'hFF)
			r = (f[22:0] != 23'd0) ? BfQnan : {f[31], 15'h7F80};
		else if (f[30:23] == 8'd0)
			r = {f[31], 15'd0};
		else
			r = {f[31], mag[30:16]};
		return r;
	endfunction

endpackage

// ===== rtl/codebook_dequant_3bit_bf16_top.sv =====
// Top level of the 3-bit codebook dequantizer with bfloat16 results.
// Usage:
//   Input: raise start with packed_codes and scale_single; a group is
//   transferred at each clock edge where start is high and busy is low.
//   busy is always low, so one group can enter every cycle.
//   Config: cfg_we, cfg_index, cfg_data write codebook entry cfg_index
//   (0..7) at a clock edge; other indexes are ignored. Write only when idle.
//   Output: done pulses for one cycle with lanes_0_to_3 .. lanes_12_to_15.
//   Pipeline: an accepted group passes three registers on its way to done (scale
//   rounding register, multiplier register in each of the 16 lanes, output
//   register). Throughput: one group per cycle, set by the 16 parallel
//   lanes, each with one 8x8 mantissa multiplier.
//   Reset: arst_n low clears the pipeline valids and loads the default
//   codebook. The receiver cannot stall; results are never held.
module codebook_dequant_3bit_bf16_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [47:0] packed_codes,
	input  logic [31:0] scale_single,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [63:0] lanes_0_to_3,
	output logic [63:0] lanes_4_to_7,
	output logic [63:0] lanes_8_to_11,
	output logic [63:0] lanes_12_to_15
);

	cbdq_pkg::codebook_t book_q;
	cbdq_pkg::bf16_t     scale_s1;
	logic [47:0]         codes_s1;
	logic                vld_s1, vld_s2;
	cbdq_pkg::bf16_t [cbdq_pkg::NumLanes-1:0] res;
	logic [255:0]        merged;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			book_q <= cbdq_pkg::CodeReset;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			if (cfg_we)
				book_q[cfg_index] <= cfg_data;
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		scale_s1 <= cbdq_pkg::scale_to_bf16(scale_single);
		codes_s1 <= packed_codes;
	end

	for (genvar k = 0; k < cbdq_pkg::NumLanes; k++) begin : g_lane
		cbdq_lane u_lane (
			.clk    (clk),
			.code   (codes_s1[k*cbdq_pkg::CodeW +: cbdq_pkg::CodeW]),
			.book   (book_q),
			.scale  (scale_s1),
			.result (res[k])
		);
	end

	// merge: lane n lands at bits 16n of the packed result
	assign merged = res;

	always_ff @(posedge clk) begin
		lanes_0_to_3   <= merged[63:0];
		lanes_4_to_7   <= merged[127:64];
		lanes_8_to_11  <= merged[191:128];
		lanes_12_to_15 <= merged[255:192];
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done) else $error("missing done");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3)) else $error("spurious done");
	a_never_busy: assert property (@(posedge clk) !busy) else $error("busy high");
`endif

endmodule

// ===== rtl/cbdq_lane.sv =====
// One lane: codebook lookup, mantissa multiply, then rounding to bfloat16.
module cbdq_lane (
	input  logic                          clk,
	input  logic [cbdq_pkg::CodeW-1:0]    code,
	input  cbdq_pkg::codebook_t           book,
	input  cbdq_pkg::bf16_t               scale,
	output cbdq_pkg::bf16_t               result
);

	cbdq_pkg::bf16_t   a;
	cbdq_pkg::lane_mid_t mid_c, mid_s2;
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [15:0] q;
	logic [9:0]  e;
	logic [8:0]  kept;
	logic [7:0]  rem;
	logic        up;

	assign a = book[code];

	always_comb begin
		nan_a  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
		nan_b  = (scale[14:7] == 8'hFF) && (scale[6:0] != 7'd0);
		inf_a  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
		inf_b  = (scale[14:7] == 8'hFF) && (scale[6:0] == 7'd0);
		zero_a = (a[14:7] == 8'd0);
		zero_b = (scale[14:7] == 8'd0);
		mid_c.sign = a[15] ^ scale[15];
		mid_c.nan  = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
		mid_c.inf  = inf_a || inf_b;
		mid_c.zero = zero_a || zero_b;
		mid_c.esum = {1'b0, a[14:7]} + {1'b0, scale[14:7]};
		mid_c.prod = {8'd0, 1'b1, a[6:0]} * {8'd0, 1'b1, scale[6:0]};
	end

	always_ff @(posedge clk) begin
		mid_s2 <= mid_c;
	end

	always_comb begin
		if (mid_s2.prod[15]) begin
			q = mid_s2.prod;
			e = {1'b0, mid_s2.esum} - 10'd126;
		end else begin
			q = {mid_s2.prod[14:0], 1'b0};
			e = {1'b0, mid_s2.esum} - 10'd127;
		end
		kept = {1'b0, q[15:8]};
		rem  = q[7:0];
		up   = (rem > 8'h80) || ((rem == 8'h80) && kept[0]);
		if (up) begin
			kept = kept + 9'd1;
			if (kept[8]) begin
				kept = 9'h080;
				e    = e + 10'd1;
			end
		end
		if (mid_s2.nan)
			result = cbdq_pkg::BfQnan;
		else if (mid_s2.inf)
			result = {mid_s2.sign, 15'h7F80};
		else if (mid_s2.zero)
			result = {mid_s2.sign, 15'd0};
		else if (!e[9] && e >= 10'd255)
			result = {mid_s2.sign, 15'h7F80};
		else if (e[9] || e == 10'd0)
			result = {mid_s2.sign, 15'd0};
		else
			result = {mid_s2.sign, e[7:0], kept[6:0]};
	end

endmodule
